// ----- rtl/pcsw_pkg.sv -----
`default_nettype none

package pcsw_pkg;

    // Register file geometry.
    localparam int REG_COUNT  = 64;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);

    // Command codes carried in the input tuser.
    localparam logic [2:0] CMD_REG_WRITE = 3'd0;
    localparam logic [2:0] CMD_REG_READ  = 3'd1;
    localparam logic [2:0] CMD_MEM_CYCLE = 3'd2;
    localparam logic [2:0] CMD_IO_CYCLE  = 3'd3;
    localparam logic [2:0] CMD_PIN_UPD   = 3'd4;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_IDENT  = 6'h00;
    localparam logic [REG_IDX_W-1:0] REG_STATUS = 6'h01;
    localparam logic [REG_IDX_W-1:0] REG_POWER  = 6'h02;
    localparam logic [REG_IDX_W-1:0] REG_INTCTL = 6'h03;
    localparam logic [REG_IDX_W-1:0] REG_CHANGE = 6'h04;
    localparam logic [REG_IDX_W-1:0] REG_CHGCFG = 6'h05;
    localparam logic [REG_IDX_W-1:0] REG_WINEN  = 6'h06;
    localparam logic [REG_IDX_W-1:0] REG_IOCTL  = 6'h07;

    // Window register blocks.
    localparam int IO_BASE    = 8;
    localparam int IO_STRIDE  = 4;
    localparam int IO_SLOT    = IO_BASE / IO_STRIDE;
    localparam int IO_WINDOWS = 2;
    localparam int MAP_BASE   = 16;
    localparam int MAP_STRIDE = 8;
    localparam int MAP_SLOT   = MAP_BASE / MAP_STRIDE;

    // Byte offsets inside a memory window block.
    localparam logic [2:0] MAP_START_LO = 3'd0;
    localparam logic [2:0] MAP_START_HI = 3'd1;
    localparam logic [2:0] MAP_STOP_LO  = 3'd2;
    localparam logic [2:0] MAP_STOP_HI  = 3'd3;
    localparam logic [2:0] MAP_OFF_LO   = 3'd4;
    localparam logic [2:0] MAP_OFF_HI   = 3'd5;

    // Byte offsets inside an io window block.
    localparam logic [1:0] IO_START_LO = 2'd0;
    localparam logic [1:0] IO_START_HI = 2'd1;
    localparam logic [1:0] IO_STOP_LO  = 2'd2;
    localparam logic [1:0] IO_STOP_HI  = 2'd3;

    // Bit positions and constant values.
    localparam logic [7:0] ID_VALUE      = 8'h83;
    localparam int         POWER_EN_BIT  = 4;
    localparam int         NOT_RESET_BIT = 6;
    localparam int         CHANGE_BIT    = 3;
    localparam int         IO_EN_LSB     = 6;
    localparam int         WIDE_BIT      = 7;
    localparam int         ATTR_BIT      = 6;

    // Input item without the command.
    typedef struct packed {
        logic        pin_ready;
        logic        pin_wrprot;
        logic [1:0]  pin_battery;
        logic [1:0]  pin_detect;
        logic [15:0] io_port;
        logic [23:0] mem_addr;
        logic [7:0]  write_data;
        logic [5:0]  reg_index;
    } in_item_t;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic        card_in_reset;
        logic [3:0]  irq_line;
        logic        irq_request;
        logic        io_wide;
        logic        io_window;
        logic        io_hit;
        logic        mem_wide;
        logic        attr_space;
        logic [25:0] card_addr;
        logic [2:0]  mem_window;
        logic        mem_hit;
        logic [7:0]  read_data;
    } result_t;

    localparam int IN_ITEM_W = $bits(in_item_t);
    localparam int RESULT_W  = $bits(result_t);

endpackage

`default_nettype wire

// ----- rtl/pc_card_socket_window_controller.sv -----
`default_nettype none

// One socket of a PC card controller: an indexed 64-byte register file with
// register reads and writes, memory and io window decode, and card pin updates.
// It takes one item per clock cycle while the output side does not stall. Its
// result passes through the input register (where the register file memory is
// read) and then the result register, which a stalled output side holds while
// the input register still takes the next item. Window decode is a
// set of parallel compares against flip-flop copies of the window registers,
// followed by one 14-bit offset add. The register file itself is a 64 x 8
// memory with one valid bit per entry, so it reads as zero after reset without
// a clearing pass. State changes (writes, status clear on read, pin updates)
// take effect at the edge that accepts the item; the status outputs show the
// state after that item.
module pc_card_socket_window_controller #(
    parameter int MEM_WINDOWS = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // reg_index[5:0], write_data[13:6], mem_addr[37:14], io_port[53:38],
    // pin_detect[55:54], pin_battery[57:56], pin_wrprot[58], pin_ready[59]
    input  wire logic [63:0]                   s_axis_tdata,
    // cmd[2:0]
    input  wire logic [2:0]                    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // read_data[7:0], mem_hit[8], mem_window[11:9], card_addr[37:12],
    // attr_space[38], mem_wide[39], io_hit[40], io_window[41], io_wide[42],
    // irq_request[43], irq_line[47:44], card_in_reset[48]
    output logic [55:0]                        m_axis_tdata
);

    import pcsw_pkg::*;

    // Handshake and pipeline control.
    logic     accept;
    logic     advance;
    logic     s1_valid_reg;
    logic     out_valid_reg;
    in_item_t in_item;
    logic     is_write;
    logic     writable;

    // Register file memory and its valid bits.
    logic [7:0]           regfile_mem [REG_COUNT];
    logic [REG_COUNT-1:0] entry_vld_reg;

    // Flip-flop copies of the registers that the decode logic uses.
    logic [5:0]             pin_reg;
    logic                   chg_reg;
    logic                   power_reg;
    logic                   not_reset_reg;
    logic                   chg_en_reg;
    logic [3:0]             irq_line_reg;
    logic [MEM_WINDOWS-1:0] win_en_reg;
    logic [IO_WINDOWS-1:0]  io_en_reg;
    logic [IO_WINDOWS-1:0]  io_wide_reg;
    logic [11:0]            win_start_reg [MEM_WINDOWS];
    logic [11:0]            win_stop_reg  [MEM_WINDOWS];
    logic [13:0]            win_off_reg   [MEM_WINDOWS];
    logic                   win_attr_reg  [MEM_WINDOWS];
    logic                   win_wide_reg  [MEM_WINDOWS];
    logic [15:0]            io_start_reg  [IO_WINDOWS];
    logic [15:0]            io_stop_reg   [IO_WINDOWS];

    // Input register stage.
    logic [2:0]  s1_cmd_reg;
    logic [23:0] s1_maddr_reg;
    logic [15:0] s1_port_reg;
    logic [7:0]  s1_fix_reg;
    logic        s1_use_mem_reg;
    logic        s1_mem_vld_reg;
    logic [7:0]  mem_rd_reg;

    // Result stage.
    result_t out_next;
    result_t out_reg;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_item       = in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
    assign is_write      = accept && (s_axis_tuser == CMD_REG_WRITE);
    assign writable      = (in_item.reg_index != REG_IDENT) &&
                           (in_item.reg_index != REG_STATUS) &&
                           (in_item.reg_index != REG_CHANGE);

    // Register file memory: written and read at the accept edge.
    always_ff @(posedge clk)
    begin
        if (is_write && writable)
        begin
            regfile_mem[in_item.reg_index] <= in_item.write_data;
        end
        if (accept)
        begin
            mem_rd_reg <= regfile_mem[in_item.reg_index];
        end
    end

    // Valid bits of the register file entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg <= '0;
        end
        else if (is_write && writable)
        begin
            entry_vld_reg[in_item.reg_index] <= 1'b1;
        end
    end

    // Control registers, window copies, pins and the status change flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_reg       <= '0;
            chg_reg       <= 1'b0;
            power_reg     <= 1'b0;
            not_reset_reg <= 1'b0;
            chg_en_reg    <= 1'b0;
            irq_line_reg  <= '0;
            win_en_reg    <= '0;
            io_en_reg     <= '0;
            io_wide_reg   <= '0;
            for (int w = 0; w < MEM_WINDOWS; w++)
            begin
                win_start_reg[w] <= '0;
                win_stop_reg[w]  <= '0;
                win_off_reg[w]   <= '0;
                win_attr_reg[w]  <= 1'b0;
                win_wide_reg[w]  <= 1'b0;
            end
            for (int i = 0; i < IO_WINDOWS; i++)
            begin
                io_start_reg[i] <= '0;
                io_stop_reg[i]  <= '0;
            end
        end
        else if (accept)
        begin
            unique case (s_axis_tuser)
                CMD_REG_WRITE:
                begin
                    if (in_item.reg_index == REG_POWER)
                        power_reg <= in_item.write_data[POWER_EN_BIT];
                    if (in_item.reg_index == REG_INTCTL)
                        not_reset_reg <= in_item.write_data[NOT_RESET_BIT];
                    if (in_item.reg_index == REG_CHGCFG)
                    begin
                        chg_en_reg   <= in_item.write_data[CHANGE_BIT];
                        irq_line_reg <= in_item.write_data[7:4];
                    end
                    if (in_item.reg_index == REG_WINEN)
                    begin
                        win_en_reg <= in_item.write_data[MEM_WINDOWS-1:0];
                        io_en_reg  <= in_item.write_data[IO_EN_LSB +: IO_WINDOWS];
                    end
                    if (in_item.reg_index == REG_IOCTL)
                    begin
                        io_wide_reg <= {in_item.write_data[4], in_item.write_data[0]};
                    end
                    // Memory window blocks.
                    for (int w = 0; w < MEM_WINDOWS; w++)
                    begin
                        if (in_item.reg_index[5:3] == 3'(MAP_SLOT + w))
                        begin
                            unique case (in_item.reg_index[2:0])
                                MAP_START_LO: win_start_reg[w][7:0] <= in_item.write_data;
                                MAP_START_HI:
                                begin
                                    win_start_reg[w][11:8] <= in_item.write_data[3:0];
                                    win_wide_reg[w]        <= in_item.write_data[WIDE_BIT];
                                end
                                MAP_STOP_LO:  win_stop_reg[w][7:0]  <= in_item.write_data;
                                MAP_STOP_HI:  win_stop_reg[w][11:8] <= in_item.write_data[3:0];
                                MAP_OFF_LO:   win_off_reg[w][7:0]   <= in_item.write_data;
                                MAP_OFF_HI:
                                begin
                                    win_off_reg[w][13:8] <= in_item.write_data[5:0];
                                    win_attr_reg[w]      <= in_item.write_data[ATTR_BIT];
                                end
                                default: ;
                            endcase
                        end
                    end
                    // IO window blocks.
                    for (int i = 0; i < IO_WINDOWS; i++)
                    begin
                        if (in_item.reg_index[5:2] == 4'(IO_SLOT + i))
                        begin
                            unique case (in_item.reg_index[1:0])
                                IO_START_LO: io_start_reg[i][7:0]  <= in_item.write_data;
                                IO_START_HI: io_start_reg[i][15:8] <= in_item.write_data;
                                IO_STOP_LO:  io_stop_reg[i][7:0]   <= in_item.write_data;
                                IO_STOP_HI:  io_stop_reg[i][15:8]  <= in_item.write_data;
                            endcase
                        end
                    end
                end
                CMD_REG_READ:
                begin
                    // Reading the status change register clears it.
                    if (in_item.reg_index == REG_CHANGE)
                        chg_reg <= 1'b0;
                end
                CMD_PIN_UPD:
                begin
                    if ((in_item.pin_detect != pin_reg[3:2]) && chg_en_reg)
                        chg_reg <= 1'b1;
                    pin_reg <= {in_item.pin_ready, in_item.pin_wrprot,
                                in_item.pin_detect, in_item.pin_battery};
                end
                default: ;
            endcase
        end
    end

    // Input register: the fields that the result stage needs.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg     <= s_axis_tuser;
            s1_maddr_reg   <= in_item.mem_addr;
            s1_port_reg    <= in_item.io_port;
            s1_mem_vld_reg <= entry_vld_reg[in_item.reg_index];
            s1_use_mem_reg <= writable;
            if (in_item.reg_index == REG_IDENT)
                s1_fix_reg <= ID_VALUE;
            else if (in_item.reg_index == REG_STATUS)
                s1_fix_reg <= {1'b0, power_reg, pin_reg};
            else
                s1_fix_reg <= {4'b0, chg_reg, 3'b0};
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Result logic: register read select, window decode and status outputs.
    always_comb
    begin
        logic [11:0]            page;
        logic [MEM_WINDOWS-1:0] mhit;
        logic [IO_WINDOWS-1:0]  ihit;
        logic [13:0]            off_sel;
        logic [13:0]            card_page;

        out_next  = '0;
        page      = s1_maddr_reg[23:12];
        off_sel   = '0;
        card_page = '0;

        for (int w = 0; w < MEM_WINDOWS; w++)
        begin
            mhit[w] = win_en_reg[w] && (page >= win_start_reg[w]) &&
                      (page <= win_stop_reg[w]);
        end
        for (int i = 0; i < IO_WINDOWS; i++)
        begin
            ihit[i] = io_en_reg[i] && (s1_port_reg >= io_start_reg[i]) &&
                      (s1_port_reg <= io_stop_reg[i]);
        end

        unique case (s1_cmd_reg)
            CMD_REG_READ:
            begin
                if (!s1_use_mem_reg)
                    out_next.read_data = s1_fix_reg;
                else if (s1_mem_vld_reg)
                    out_next.read_data = mem_rd_reg;
            end
            CMD_MEM_CYCLE:
            begin
                // Lowest-numbered matching window wins.
                for (int w = MEM_WINDOWS - 1; w >= 0; w--)
                begin
                    if (mhit[w])
                    begin
                        out_next.mem_hit    = 1'b1;
                        out_next.mem_window = 3'(w);
                        out_next.attr_space = win_attr_reg[w];
                        out_next.mem_wide   = win_wide_reg[w];
                        off_sel             = win_off_reg[w];
                    end
                end
                card_page = {2'b0, page} + off_sel;
                if (out_next.mem_hit)
                    out_next.card_addr = {card_page, s1_maddr_reg[11:0]};
            end
            CMD_IO_CYCLE:
            begin
                for (int i = IO_WINDOWS - 1; i >= 0; i--)
                begin
                    if (ihit[i])
                    begin
                        out_next.io_hit    = 1'b1;
                        out_next.io_window = 1'(i);
                        out_next.io_wide   = io_wide_reg[i];
                    end
                end
            end
            default: ;
        endcase

        out_next.irq_request   = chg_reg;
        out_next.irq_line      = irq_line_reg;
        out_next.card_in_reset = !not_reset_reg;
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(56 - RESULT_W)'(0), out_reg};

    // A memory hit always names an existing window.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.mem_hit |-> out_reg.mem_window < 3'(MEM_WINDOWS))
        else $error("memory hit names a window that does not exist");

    // One item never reports both a memory and an io hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.mem_hit && out_reg.io_hit))
        else $error("memory and io hit reported together");

    // A stalled item stays in the input register unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_cmd_reg))
        else $error("input register lost a stalled item");

    // The status change flag only sets while detect change is enabled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(chg_reg) |-> $past(chg_en_reg))
        else $error("status change set while detect change disabled");

endmodule

`default_nettype wire

// ----- dv/pc_card_socket_window_controller_tb.sv -----
`timescale 1ns / 100ps

module pc_card_socket_window_controller_tb;

    import pcsw_pkg::*;

    localparam int MEM_WINDOWS   = 5;
    localparam int RANDOM_ITEMS  = 850;
    localparam int PHASES        = 4;
    localparam int HOLD_CYCLES   = 200;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [2:0] CMD_LAST = CMD_PIN_UPD;

    // Socket predictor and result checker.
    class socket_scoreboard;
        bit [7:0] regs [REG_COUNT];
        bit [5:0] pins;
        result_t  socket_results_due [$];
        int       failures;
        int       n_windows;

        function new(int windows);
            n_windows = windows;
            foreach (regs[i])
                regs[i] = 8'h00;
            pins = 6'h00;
            failures = 0;
        endfunction

        function int pending();
            return socket_results_due.size();
        endfunction

        // Applies one command to the register file and returns the result it gives.
        function result_t socket_result(logic [2:0] cmd, in_item_t it);
            result_t   r;
            bit        found;
            int        b;
            bit [11:0] page;
            bit [11:0] lo12;
            bit [11:0] hi12;
            bit [13:0] off;
            bit [15:0] lo16;
            bit [15:0] hi16;
            bit [5:0]  np;
            r = '0;
            found = 1'b0;
            case (cmd)
                CMD_REG_WRITE:
                begin
                    if (it.reg_index != REG_IDENT && it.reg_index != REG_STATUS &&
                        it.reg_index != REG_CHANGE)
                        regs[it.reg_index] = it.write_data;
                end
                CMD_REG_READ:
                begin
                    if (it.reg_index == REG_IDENT)
                        r.read_data = ID_VALUE;
                    else if (it.reg_index == REG_STATUS)
                        r.read_data = {1'b0, regs[REG_POWER][POWER_EN_BIT], pins};
                    else
                    begin
                        r.read_data = regs[it.reg_index];
                        // The status change register clears when read.
                        if (it.reg_index == REG_CHANGE)
                            regs[REG_CHANGE] = 8'h00;
                    end
                end
                CMD_MEM_CYCLE:
                begin
                    page = it.mem_addr[23:12];
                    for (int w = 0; w < n_windows && !found; w++)
                    begin
                        b = MAP_BASE + w * MAP_STRIDE;
                        lo12 = {regs[b + MAP_START_LO + 1][3:0], regs[b + MAP_START_LO]};
                        hi12 = {regs[b + MAP_STOP_HI][3:0], regs[b + MAP_STOP_LO]};
                        if (regs[REG_WINEN][w] && page >= lo12 && page <= hi12)
                        begin
                            found = 1'b1;
                            off = {regs[b + MAP_OFF_HI][5:0], regs[b + MAP_OFF_LO]};
                            r.mem_hit = 1'b1;
                            r.mem_window = 3'(w);
                            r.card_addr = 26'(it.mem_addr) + {off, 12'h000};
                            r.attr_space = regs[b + MAP_OFF_HI][ATTR_BIT];
                            r.mem_wide = regs[b + MAP_START_HI][WIDE_BIT];
                        end
                    end
                end
                CMD_IO_CYCLE:
                begin
                    for (int w = 0; w < IO_WINDOWS && !found; w++)
                    begin
                        b = IO_BASE + w * IO_STRIDE;
                        lo16 = {regs[b + IO_START_HI], regs[b + IO_START_LO]};
                        hi16 = {regs[b + IO_STOP_HI], regs[b + IO_STOP_LO]};
                        if (regs[REG_WINEN][IO_EN_LSB + w] && it.io_port >= lo16 &&
                            it.io_port <= hi16)
                        begin
                            found = 1'b1;
                            r.io_hit = 1'b1;
                            r.io_window = 1'(w);
                            // One nibble of io control per window.
                            r.io_wide = regs[REG_IOCTL][4 * w];
                        end
                    end
                end
                CMD_PIN_UPD:
                begin
                    np = {it.pin_ready, it.pin_wrprot, it.pin_detect, it.pin_battery};
                    if (np[3:2] != pins[3:2] && regs[REG_CHGCFG][CHANGE_BIT])
                        regs[REG_CHANGE][CHANGE_BIT] = 1'b1;
                    pins = np;
                end
                default:
                    ;
            endcase
            r.irq_request = regs[REG_CHANGE][CHANGE_BIT];
            r.irq_line = regs[REG_CHGCFG][7:4];
            r.card_in_reset = !regs[REG_INTCTL][NOT_RESET_BIT];
            return r;
        endfunction

        function void note_command(logic [2:0] cmd, in_item_t it);
            socket_results_due.push_back(socket_result(cmd, it));
        endfunction

        function string field_diff(string name, logic [25:0] want, logic [25:0] got);
            if (want !== got)
                return $sformatf(" %s exp=%0h got=%0h", name, want, got);
            return "";
        endfunction

        // Compares one delivered result with the oldest expectation.
        function void check_result(result_t got);
            result_t want;
            string   diff;
            if (socket_results_due.size() == 0)
            begin
                if (failures < REPORT_LIMIT)
                    $display("%0t: result with nothing expected: %h", $realtime, got);
                failures++;
                return;
            end
            want = socket_results_due.pop_front();
            diff = {field_diff("read_data", want.read_data, got.read_data),
                    field_diff("mem_hit", want.mem_hit, got.mem_hit),
                    field_diff("mem_window", want.mem_window, got.mem_window),
                    field_diff("card_addr", want.card_addr, got.card_addr),
                    field_diff("attr_space", want.attr_space, got.attr_space),
                    field_diff("mem_wide", want.mem_wide, got.mem_wide),
                    field_diff("io_hit", want.io_hit, got.io_hit),
                    field_diff("io_window", want.io_window, got.io_window),
                    field_diff("io_wide", want.io_wide, got.io_wide),
                    field_diff("irq_request", want.irq_request, got.irq_request),
                    field_diff("irq_line", want.irq_line, got.irq_line),
                    field_diff("card_in_reset", want.card_in_reset, got.card_in_reset)};
            if (diff != "")
            begin
                if (failures < REPORT_LIMIT)
                    $display("%0t: mismatch, expected %h got %h:%s", $realtime, want, got,
                             diff);
                failures++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;

    socket_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_count     = 0;
    int items_sent     = 0;
    int quiet_cycles   = 0;

    pc_card_socket_window_controller #(
        .MEM_WINDOWS(MEM_WINDOWS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // 12 ns clock.
    initial
        clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Output side: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin : receiver
        int hold_seen;
        int hold_left;
        if (hold_seen != hold_count)
        begin
            hold_seen = hold_count;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitors both sides and watches for a stuck handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_command(s_axis_tuser, in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]));
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(result_t'(m_axis_tdata[RESULT_W-1:0]));
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic in_item_t rand_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return in_item_t'(raw[IN_ITEM_W-1:0]);
    endfunction

    // Offers one item, with random idle cycles first, and waits for acceptance.
    task automatic send(input logic [2:0] cmd, input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(64 - IN_ITEM_W){1'b0}}, it};
        s_axis_tuser <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Stops offering and waits until every result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [5:0] idx, input logic [7:0] data);
        in_item_t it;
        it = rand_item();
        it.reg_index = idx;
        it.write_data = data;
        send(CMD_REG_WRITE, it);
    endtask

    task automatic reg_read(input logic [5:0] idx);
        in_item_t it;
        it = rand_item();
        it.reg_index = idx;
        send(CMD_REG_READ, it);
    endtask

    task automatic mem_cycle(input logic [23:0] addr);
        in_item_t it;
        it = rand_item();
        it.mem_addr = addr;
        send(CMD_MEM_CYCLE, it);
    endtask

    task automatic io_cycle(input logic [15:0] port);
        in_item_t it;
        it = rand_item();
        it.io_port = port;
        send(CMD_IO_CYCLE, it);
    endtask

    task automatic pin_update(input logic [1:0] det, input logic [1:0] bat,
                              input logic wp, input logic rdy);
        in_item_t it;
        it = rand_item();
        it.pin_detect = det;
        it.pin_battery = bat;
        it.pin_wrprot = wp;
        it.pin_ready = rdy;
        send(CMD_PIN_UPD, it);
    endtask

    // Programs a memory window with a mostly ordered range and turns it on.
    task automatic program_map(input int w);
        int          b;
        int          lo;
        int          hi;
        logic [7:0]  data;
        b = MAP_BASE + w * MAP_STRIDE;
        lo = ($urandom_range(7) == 0) ? 0 : $urandom_range(4095);
        case ($urandom_range(9))
            0: hi = $urandom_range(4095);
            1: hi = 4095;
            default: hi = lo + $urandom_range((4095 - lo) < 64 ? (4095 - lo) : 64);
        endcase
        reg_write(6'(b + MAP_START_LO), 8'(lo));
        data = 8'($urandom);
        data[3:0] = 4'(lo >> 8);
        reg_write(6'(b + MAP_START_HI), data);
        reg_write(6'(b + MAP_STOP_LO), 8'(hi));
        data = 8'($urandom);
        data[3:0] = 4'(hi >> 8);
        reg_write(6'(b + MAP_STOP_HI), data);
        reg_write(6'(b + MAP_OFF_LO), 8'($urandom));
        reg_write(6'(b + MAP_OFF_HI), 8'($urandom));
        data = 8'($urandom);
        data[w] = 1'b1;
        reg_write(REG_WINEN, data);
    endtask

    task automatic program_io(input int w);
        int         b;
        int         lo;
        int         hi;
        logic [7:0] data;
        b = IO_BASE + w * IO_STRIDE;
        lo = $urandom_range(65535);
        if ($urandom_range(9) == 0)
            hi = $urandom_range(65535);
        else
            hi = lo + $urandom_range((65535 - lo) < 512 ? (65535 - lo) : 512);
        reg_write(6'(b + IO_START_LO), 8'(lo));
        reg_write(6'(b + IO_START_HI), 8'(lo >> 8));
        reg_write(6'(b + IO_STOP_LO), 8'(hi));
        reg_write(6'(b + IO_STOP_HI), 8'(hi >> 8));
        reg_write(REG_IOCTL, 8'($urandom));
        data = 8'($urandom);
        data[IO_EN_LSB + w] = 1'b1;
        reg_write(REG_WINEN, data);
    endtask

    // Memory cycle aimed at, or just outside, the range of a window.
    task automatic mem_targeted();
        int b;
        int lo;
        int hi;
        int page;
        b = MAP_BASE + $urandom_range(MEM_WINDOWS - 1) * MAP_STRIDE;
        lo = {sb.regs[b + MAP_START_HI][3:0], sb.regs[b + MAP_START_LO]};
        hi = {sb.regs[b + MAP_STOP_HI][3:0], sb.regs[b + MAP_STOP_LO]};
        case ($urandom_range(7))
            0: page = lo;
            1: page = hi;
            2: page = lo - 1;
            3: page = hi + 1;
            4: page = $urandom_range(4095);
            default: page = $urandom_range(hi, lo);
        endcase
        mem_cycle({12'(page), 12'($urandom)});
    endtask

    task automatic io_targeted();
        int b;
        int lo;
        int hi;
        int port;
        b = IO_BASE + $urandom_range(IO_WINDOWS - 1) * IO_STRIDE;
        lo = {sb.regs[b + IO_START_HI], sb.regs[b + IO_START_LO]};
        hi = {sb.regs[b + IO_STOP_HI], sb.regs[b + IO_STOP_LO]};
        case ($urandom_range(7))
            0: port = lo;
            1: port = hi;
            2: port = lo - 1;
            3: port = hi + 1;
            4: port = $urandom_range(65535);
            default: port = $urandom_range(hi, lo);
        endcase
        io_cycle(16'(port));
    endtask

    // One random step: window setup, decoded cycles, register traffic or pins.
    task automatic random_step();
        int         pick;
        in_item_t   it;
        logic [2:0] cmd;
        pick = $urandom_range(99);
        it = rand_item();
        if (pick < 6)
            program_map($urandom_range(MEM_WINDOWS - 1));
        else if (pick < 9)
            program_io($urandom_range(IO_WINDOWS - 1));
        else if (pick < 35)
            mem_targeted();
        else if (pick < 48)
            io_targeted();
        else if (pick < 62)
            reg_read($urandom_range(1) ? 6'($urandom_range(REG_IOCTL)) : it.reg_index);
        else if (pick < 72)
        begin
            // Half of the pin updates keep the detect pins as they are.
            if ($urandom_range(1))
                it.pin_detect = sb.pins[3:2];
            send(CMD_PIN_UPD, it);
        end
        else if (pick < 82)
            reg_write(6'($urandom_range(REG_IOCTL)), it.write_data);
        else if (pick < 90)
            send(CMD_REG_WRITE, it);
        else if (pick < 93)
        begin
            cmd = 3'($urandom_range(7, CMD_LAST + 1));
            send(cmd, it);
        end
        else
        begin
            cmd = 3'($urandom);
            send(cmd, it);
        end
    endtask

    initial
    begin
        int target;
        bit held;
        sb = new(MEM_WINDOWS);
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_REG_WRITE;
        m_axis_tready = 1'b0;
        held = 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        // Identification, read-only registers and status change handling.
        reg_read(REG_IDENT);
        reg_write(REG_IDENT, 8'hFF);
        reg_write(REG_STATUS, 8'hFF);
        reg_write(REG_CHANGE, 8'hFF);
        reg_read(REG_CHANGE);
        reg_write(REG_CHGCFG, 8'hF8);
        pin_update(2'b11, 2'b11, 1'b1, 1'b1);
        reg_read(REG_STATUS);
        reg_write(REG_POWER, 8'hFF);
        reg_read(REG_STATUS);
        reg_read(REG_CHANGE);
        reg_read(REG_CHANGE);
        // Detect change with the change interrupt disabled leaves the flag clear.
        reg_write(REG_CHGCFG, 8'h07);
        pin_update(2'b00, 2'b00, 1'b0, 1'b0);
        reg_read(REG_CHANGE);
        reg_write(REG_INTCTL, 8'h40);

        // Window 0 covers the whole space, wide, attribute, largest offset.
        reg_write(6'(MAP_BASE + MAP_START_LO), 8'h00);
        reg_write(6'(MAP_BASE + MAP_START_HI), 8'h80);
        reg_write(6'(MAP_BASE + MAP_STOP_LO), 8'hFF);
        reg_write(6'(MAP_BASE + MAP_STOP_HI), 8'h0F);
        reg_write(6'(MAP_BASE + MAP_OFF_LO), 8'hFF);
        reg_write(6'(MAP_BASE + MAP_OFF_HI), 8'h7F);
        reg_write(REG_WINEN, 8'hFF);
        mem_cycle(24'hFFFFFF);
        mem_cycle(24'h000000);
        // Stop below start disables window 0, so window 1 takes page zero.
        reg_write(6'(MAP_BASE + MAP_START_HI), 8'h8F);
        reg_write(6'(MAP_BASE + MAP_STOP_HI), 8'h00);
        mem_cycle(24'h000000);
        mem_cycle(24'h001000);
        reg_write(REG_IOCTL, 8'hFF);
        io_cycle(16'h0000);
        io_cycle(16'hFFFF);
        send(3'(CMD_LAST + 1), in_item_t'('1));
        send(3'(CMD_LAST + 2), in_item_t'('1));
        send(3'(CMD_LAST + 3), in_item_t'('0));
        drain();

        // Random traffic under four idling patterns.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 59;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 59;
                end
                default:
                begin
                    send_idle_pct = 14;
                    recv_stall_pct = 14;
                end
            endcase
            target = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target)
            begin
                random_step();
                // Long output hold-off while input keeps coming, to back up the pipe.
                if (phase == 0 && !held && items_sent >= target - RANDOM_ITEMS / 8)
                begin
                    held = 1'b1;
                    hold_count++;
                end
            end
            drain();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
